>>> rtl/ole_pkg.sv
package ole_pkg;

    // opcodes
    localparam logic [3:0] OP_PUSH_FRONT = 4'd0;
    localparam logic [3:0] OP_PUSH_BACK  = 4'd1;
    localparam logic [3:0] OP_INSERT_AT  = 4'd2;
    localparam logic [3:0] OP_POP_FRONT  = 4'd3;
    localparam logic [3:0] OP_POP_BACK   = 4'd4;
    localparam logic [3:0] OP_REMOVE_AT  = 4'd5;
    localparam logic [3:0] OP_REMOVE_VAL = 4'd6;
    localparam logic [3:0] OP_SEARCH     = 4'd7;
    localparam logic [3:0] OP_REPLACE    = 4'd8;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_RANGE    = 3'd1;
    localparam logic [2:0] ST_EMPTY    = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FULL     = 3'd4;

    typedef struct packed {
        logic [3:0]         opcode;
        logic signed [31:0] item_value;
        logic [6:0]         position;
        logic signed [31:0] replacement;
    } t_cmd;

    typedef struct packed {
        logic [2:0] status;
        logic       found;
        logic [6:0] count_after;
    } t_res;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic cap;       // capture compare result this cycle
        logic use_match; // position comes from the first match
        logic use_num;   // position comes from the numeric target
        logic shr;       // open a gap at the position, load data there
        logic shl;       // close the cell at the position
        logic wr;        // overwrite the cell at the position
    } t_cell_ctl;

endpackage

>>> rtl/ole_cell.sv
module ole_cell #(
    parameter int INDEX = 0,
    parameter int WW    = 7
) (
    input  logic              i_clk,
    input  ole_pkg::t_cell_ctl i_ctl,
    input  logic [31:0]       i_key,
    input  logic [31:0]       i_data,
    input  logic [WW-1:0]     i_cnt,
    input  logic [WW-1:0]     i_tgt,
    input  logic [31:0]       i_left_val,
    input  logic [31:0]       i_right_val,
    input  logic              i_ge_prev,
    input  logic              i_mge_prev,
    output logic              o_ge,
    output logic              o_mge,
    output logic [31:0]       o_val
);
    import ole_pkg::*;

    localparam logic [WW-1:0] IDX = WW'(INDEX);

    logic [31:0] r_val;
    logic        r_hit;
    logic        w_eq;

    // prefix OR of live matches from the front up to this cell
    assign o_mge = i_mge_prev | r_hit;
    assign o_ge  = (i_ctl.use_match & o_mge) | (i_ctl.use_num & (IDX >= i_tgt));
    assign w_eq  = o_ge & ~i_ge_prev;
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cap) begin
            r_hit <= (r_val == i_key) && (IDX < i_cnt);
        end
        if (i_ctl.shr) begin
            if (w_eq) begin
                r_val <= i_data;
            end else if (i_ge_prev) begin
                r_val <= i_left_val;
            end
        end else if (i_ctl.shl) begin
            if (o_ge) begin
                r_val <= i_right_val;
            end
        end else if (i_ctl.wr) begin
            if (w_eq) begin
                r_val <= i_data;
            end
        end
    end

endmodule

>>> rtl/ordered_list_engine.sv
// Ordered list engine: keeps up to CAPACITY signed 32-bit values in a row of
// cells, cell 0 being the front. A command beat is taken when start is high
// and busy is low; every command returns exactly one result beat on o_res,
// marked by o_done for one cycle, which the receiver cannot hold off.
// Each command has a compare step and an update step: in the cycle after
// the accept every cell compares its value with the key (busy is high), and
// in the next cycle the first-match mark ripples down the cell chain and all
// cells shift, load or hold at once at the closing edge; a new command may
// be accepted at that same edge. o_done rises in the cycle after the update.
// Cells at or above the element count hold stale data that is never
// observed. Refused pushes report a full status and leave the list
// untouched.
module ordered_list_engine #(
    parameter int CAPACITY = 64
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    input  ole_pkg::t_cmd i_cmd,
    output logic          o_done,
    output ole_pkg::t_res o_res
);
    import ole_pkg::*;

    localparam int CW = $clog2(CAPACITY + 1);   // element count width
    localparam int WW = (CW > 7) ? CW : 7;      // compare width for count/position

    // sequencer: r_s1 = compare cycle, r_s2 = update cycle
    logic          r_s1;
    logic          r_s2;
    t_cmd          r_cmd;
    logic [CW-1:0] r_count;
    logic          r_done;
    t_res          r_res;

    logic [CW-1:0] n_count;
    logic [2:0]    w_status;
    logic          w_found;
    t_cell_ctl     w_ctl;
    logic [WW-1:0] w_tgt;
    logic [31:0]   w_data;
    logic [WW-1:0] w_cnt;
    logic [WW-1:0] w_pos;
    logic          w_full;
    logic          w_empty;
    logic          w_any;

    logic [31:0] w_val [CAPACITY];
    logic        w_ge  [CAPACITY];
    logic        w_mge [CAPACITY];

    assign busy   = r_s1;
    assign o_done = r_done;
    assign o_res  = r_res;

    assign w_cnt   = WW'(r_count);
    assign w_pos   = WW'(r_cmd.position);
    assign w_full  = r_count >= CW'(CAPACITY);
    assign w_empty = r_count == '0;
    assign w_any   = w_mge[CAPACITY-1];   // some live cell matched the key

    // cell chain
    for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
        logic [31:0] w_left;
        logic [31:0] w_right;
        logic        w_gep;
        logic        w_mgep;
        if (k == 0) begin : g_front
            assign w_left = '0;
            assign w_gep  = 1'b0;
            assign w_mgep = 1'b0;
        end else begin : g_mid
            assign w_left = w_val[k-1];
            assign w_gep  = w_ge[k-1];
            assign w_mgep = w_mge[k-1];
        end
        if (k == CAPACITY - 1) begin : g_back
            assign w_right = w_val[k];
        end else begin : g_inner
            assign w_right = w_val[k+1];
        end

        ole_cell #(
            .INDEX (k),
            .WW    (WW)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_key       (r_cmd.item_value),
            .i_data      (w_data),
            .i_cnt       (w_cnt),
            .i_tgt       (w_tgt),
            .i_left_val  (w_left),
            .i_right_val (w_right),
            .i_ge_prev   (w_gep),
            .i_mge_prev  (w_mgep),
            .o_ge        (w_ge[k]),
            .o_mge       (w_mge[k]),
            .o_val       (w_val[k])
        );
    end

    // update decode: capture strobe in the compare cycle, cell moves in the update cycle
    always_comb begin
        w_ctl           = '0;
        w_ctl.cap       = r_s1;
        w_ctl.use_match = (r_cmd.opcode == OP_REMOVE_VAL) || (r_cmd.opcode == OP_SEARCH)
                          || (r_cmd.opcode == OP_REPLACE);
        w_tgt    = '0;
        w_data   = r_cmd.item_value;
        n_count  = r_count;
        w_status = ST_OK;
        w_found  = 1'b0;
        if (r_s2) begin
            unique case (r_cmd.opcode)
                OP_PUSH_FRONT, OP_PUSH_BACK: begin
                    if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctl.use_num = 1'b1;
                        w_ctl.shr     = 1'b1;
                        w_tgt         = (r_cmd.opcode == OP_PUSH_FRONT) ? '0 : w_cnt;
                        n_count       = r_count + CW'(1);
                    end
                end
                OP_INSERT_AT: begin
                    if (w_pos > w_cnt) begin
                        w_status = ST_RANGE;
                    end else if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        w_ctl.use_num = 1'b1;
                        w_ctl.shr     = 1'b1;
                        w_tgt         = w_pos;
                        n_count       = r_count + CW'(1);
                    end
                end
                OP_POP_FRONT: begin
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        w_ctl.use_num = 1'b1;
                        w_ctl.shl     = 1'b1;
                        n_count       = r_count - CW'(1);
                    end
                end
                OP_POP_BACK: begin
                    // dropping the tail needs no data movement
                    if (w_empty) begin
                        w_status = ST_EMPTY;
                    end else begin
                        n_count = r_count - CW'(1);
                    end
                end
                OP_REMOVE_AT: begin
                    if (w_pos >= w_cnt) begin
                        w_status = ST_RANGE;
                    end else begin
                        w_ctl.use_num = 1'b1;
                        w_ctl.shl     = 1'b1;
                        w_tgt         = w_pos;
                        n_count       = r_count - CW'(1);
                    end
                end
                OP_REMOVE_VAL: begin
                    if (w_any) begin
                        w_found   = 1'b1;
                        w_ctl.shl = 1'b1;
                        n_count   = r_count - CW'(1);
                    end else begin
                        w_status = ST_NOTFOUND;
                    end
                end
                OP_SEARCH: begin
                    if (w_any) begin
                        w_found = 1'b1;
                    end else begin
                        w_status = ST_NOTFOUND;
                    end
                end
                OP_REPLACE: begin
                    w_data = r_cmd.replacement;
                    if (w_any) begin
                        w_found  = 1'b1;
                        w_ctl.wr = 1'b1;
                    end else if (w_full) begin
                        w_status = ST_FULL;
                    end else begin
                        // no match: push replacement at the front
                        w_ctl.use_num = 1'b1;
                        w_ctl.shr     = 1'b1;
                        n_count       = r_count + CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1    <= 1'b0;
            r_s2    <= 1'b0;
            r_count <= '0;
            r_done  <= 1'b0;
        end else begin
            r_s1   <= start & ~r_s1;
            r_s2   <= r_s1;
            r_done <= r_s2;
            if (r_s2) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !r_s1) begin
            r_cmd <= i_cmd;
        end
        if (r_s2) begin
            r_res.status      <= w_status;
            r_res.found       <= w_found;
            r_res.count_after <= 7'(n_count);
        end
    end

endmodule
